FILE: design/flow_sensor_frame_decoder_top_defines.svh
// assertion macros for the flow sensor frame decoder
`ifndef FLOW_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH
`define FLOW_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define FSFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fsfd assertion failed");

// antecedent holds, consequent holds in the next cycle
`define FSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fsfd assertion failed");

`endif

FILE: design/fsfd_pkg.sv
// shared types, constants and crc function of the flow sensor frame decoder
package fsfd_pkg;

    localparam int unsigned RAW_W              = 16;
    localparam int unsigned FLOW_W             = 18;
    localparam int unsigned FLOW_FRAC_BITS_DEF = 7;
    localparam int unsigned FLOW_DIVISOR       = 120;

    localparam logic [7:0]       CRC_INIT          = 8'hFF;
    localparam logic [7:0]       CRC_POLY          = 8'h31;
    localparam logic [RAW_W-1:0] INVALID_RAW       = 16'hFFFF;
    localparam logic [RAW_W-1:0] ZERO_OFFSET_RESET = 16'h8000;

    // register index, taken from paddr[2]
    localparam logic REG_ZERO_OFFSET = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUS     = 2'd1,
        ST_CRC     = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POS_WAIT_LO  = 2'd1,
        POS_WAIT_CRC = 2'd2,
        POS_IDLE     = 2'd3
    } t_frame_pos;

    // frame outcome handed to the scaling pipeline
    typedef struct packed {
        t_status          status;
        logic [RAW_W-1:0] raw;
        logic             neg;
        logic [RAW_W-1:0] mag;
    } t_frame_result;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: design/fsfd_flow_scale.sv
// two-stage flow scaling: reciprocal multiply, correction, sign and saturation
module fsfd_flow_scale #(
    parameter int unsigned FLOW_FRAC_BITS = fsfd_pkg::FLOW_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  fsfd_pkg::t_frame_result          i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_status,
    output logic signed [fsfd_pkg::FLOW_W-1:0] o_flow_q,
    output logic [fsfd_pkg::RAW_W-1:0]       o_raw_code
);
    import fsfd_pkg::*;

    // n = (mag << frac) + divisor/2, quotient = floor(n / divisor)
    localparam int unsigned NW = RAW_W + FLOW_FRAC_BITS + 1;
    localparam int unsigned RW = NW - 6;
    localparam int unsigned QW = NW - 6;
    localparam int unsigned PW = NW + RW;
    localparam int unsigned EW = ((QW > FLOW_W) ? QW : FLOW_W) + 1;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << NW) / FLOW_DIVISOR);
    localparam logic [NW-1:0] ROUND_ADD = NW'(FLOW_DIVISOR / 2);
    localparam logic [EW-1:0] POS_LIM = EW'((64'd1 << (FLOW_W - 1)) - 1);
    localparam logic [EW-1:0] NEG_LIM = EW'(64'd1 << (FLOW_W - 1));

    logic              r_s2_valid;
    t_status           r_s2_status;
    logic [RAW_W-1:0]  r_s2_raw;
    logic              r_s2_neg;
    logic [NW-1:0]     r_s2_n;
    logic [PW-1:0]     r_s2_prod;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [FLOW_W-1:0] r_out_flow;
    logic [RAW_W-1:0]  r_out_raw;

    logic              out_move;
    logic              s2_move;
    logic [NW-1:0]     n_in;
    logic [QW-1:0]     q0;
    logic [NW-1:0]     rem;
    logic [QW-1:0]     q;
    logic [EW-1:0]     q_ext;
    logic [FLOW_W-1:0] n_flow;

    assign out_move = !r_out_valid || i_ready;
    assign s2_move  = !r_s2_valid || out_move;
    assign o_ready  = s2_move;

    assign n_in = (NW'(i_item.mag) << FLOW_FRAC_BITS) + ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_move) begin
            r_s2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move && i_valid) begin
            r_s2_status <= i_item.status;
            r_s2_raw    <= i_item.raw;
            r_s2_neg    <= i_item.neg;
            r_s2_n      <= n_in;
            r_s2_prod   <= PW'(n_in) * PW'(RECIP);
        end
    end

    // estimate is low by at most one, fixed by one compare
    always_comb begin
        q0     = QW'(r_s2_prod >> NW);
        rem    = r_s2_n - NW'(q0 * FLOW_DIVISOR);
        q      = (rem >= NW'(FLOW_DIVISOR)) ? q0 + QW'(1) : q0;
        q_ext  = EW'(q);
        n_flow = '0;
        if (r_s2_status == ST_OK) begin
            if (r_s2_neg) begin
                n_flow = (q_ext >= NEG_LIM) ? NEG_LIM[FLOW_W-1:0] : -q_ext[FLOW_W-1:0];
            end else begin
                n_flow = (q_ext > POS_LIM) ? POS_LIM[FLOW_W-1:0] : q_ext[FLOW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_move) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move && r_s2_valid) begin
            r_out_status <= r_s2_status;
            r_out_flow   <= n_flow;
            r_out_raw    <= r_s2_raw;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_flow_q   = signed'(r_out_flow);
    assign o_raw_code = r_out_raw;

endmodule

FILE: design/flow_sensor_frame_decoder_top.sv
// flow sensor frame decoder: frame tracking, crc-8 check and flow scaling
//
// Input channel (i_in_valid / o_in_ready) carries one event per transaction:
// a received byte (i_kind 0, i_rx_byte, i_frame_begin) or a bus error (i_kind 1).
// A frame is data high, data low, check byte; i_frame_begin marks data high.
// Output channel (o_out_valid / i_out_ready) carries one result per check byte
// or bus error: o_status, o_flow_q (1/2^FLOW_FRAC_BITS slm) and o_raw_code.
// Data bytes and stray bytes give no result; the first complete frame after
// reset is dropped whatever its outcome.
// One input transaction is taken every cycle while o_in_ready is high. The result
// of an accepted input transaction reaches the output through three registers:
// frame/crc register, reciprocal multiply register, output register.
// When the receiver stalls, the three result registers fill up one by one and
// o_in_ready drops only once the frame register holds a result it cannot pass on.
// Reset (i_rst_n low, synchronous) empties the pipeline, ends any frame, sets
// the crc to 0xFF, the zero offset to 32768 and arms the first-frame drop.
// APB register at byte address 0: zero_offset[15:0]; pready is always high.
`include "flow_sensor_frame_decoder_top_defines.svh"

module flow_sensor_frame_decoder_top #(
    parameter int unsigned FLOW_FRAC_BITS = fsfd_pkg::FLOW_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  logic [7:0]                         i_rx_byte,
    input  logic                               i_frame_begin,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_status,
    output logic signed [fsfd_pkg::FLOW_W-1:0] o_flow_q,
    output logic [fsfd_pkg::RAW_W-1:0]         o_raw_code,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [2:0]                         i_paddr,
    input  logic [31:0]                        i_pwdata,
    output logic [31:0]                        o_prdata,
    output logic                               o_pready
);
    import fsfd_pkg::*;

    logic [RAW_W-1:0]   r_zero_offset;
    t_frame_pos         r_pos;
    t_frame_pos         n_pos;
    logic [7:0]         r_crc;
    logic [7:0]         n_crc;
    logic [RAW_W-1:0]   r_data;
    logic [RAW_W-1:0]   n_data;
    logic               r_discard;
    logic               n_discard;

    logic               r_s1_valid;
    t_frame_result      r_s1;
    t_frame_result      n_item;
    logic               emit;
    logic               accept;
    logic               s1_move;
    logic               scale_ready;
    logic signed [RAW_W:0] diff;

    // configuration port
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_ZERO_OFFSET) ? {16'b0, r_zero_offset} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= ZERO_OFFSET_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_ZERO_OFFSET)) begin
            r_zero_offset <= i_pwdata[RAW_W-1:0];
        end
    end

    assign s1_move    = !r_s1_valid || scale_ready;
    assign o_in_ready = s1_move;
    assign accept     = i_in_valid && s1_move;

    assign diff = signed'({1'b0, r_data}) - signed'({1'b0, r_zero_offset});

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_data    = r_data;
        n_discard = r_discard;
        emit      = 1'b0;
        n_item    = '{status: ST_BUS, raw: '0, neg: 1'b0, mag: '0};
        if (accept) begin
            priority if (i_kind) begin
                n_pos = POS_IDLE;
                n_crc = CRC_INIT;
                emit  = 1'b1;
            end else if (i_frame_begin) begin
                n_data = {i_rx_byte, 8'h00};
                n_crc  = crc8_byte(CRC_INIT, i_rx_byte);
                n_pos  = POS_WAIT_LO;
            end else if (r_pos == POS_WAIT_LO) begin
                n_data = {r_data[15:8], i_rx_byte};
                n_crc  = crc8_byte(r_crc, i_rx_byte);
                n_pos  = POS_WAIT_CRC;
            end else if (r_pos == POS_WAIT_CRC) begin
                n_pos      = POS_IDLE;
                n_crc      = CRC_INIT;
                n_item.raw = r_data;
                if (r_crc != i_rx_byte) begin
                    n_item.status = ST_CRC;
                end else if (r_data == INVALID_RAW) begin
                    n_item.status = ST_INVALID;
                end else begin
                    n_item.status = ST_OK;
                    n_item.neg    = diff[RAW_W];
                    n_item.mag    = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
                end
                if (r_discard) begin
                    n_discard = 1'b0;
                end else begin
                    emit = 1'b1;
                end
            end else begin
                // stray byte outside a frame
                emit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_IDLE;
            r_crc     <= CRC_INIT;
            r_data    <= '0;
            r_discard <= 1'b1;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_data    <= n_data;
            r_discard <= n_discard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && emit) begin
            r_s1 <= n_item;
        end
    end

    fsfd_flow_scale #(
        .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
    ) u_flow_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s1_valid),
        .o_ready    (scale_ready),
        .i_item     (r_s1),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_status   (o_status),
        .o_flow_q   (o_flow_q),
        .o_raw_code (o_raw_code)
    );

    `FSFD_ASSERT_NOW(a_flow_zero_unless_ok, o_out_valid && (o_status != ST_OK), o_flow_q == '0)
    `FSFD_ASSERT_NOW(a_bus_raw_zero, o_out_valid && (o_status == ST_BUS), o_raw_code == '0)
    `FSFD_ASSERT_NOW(a_invalid_raw, o_out_valid && (o_status == ST_INVALID), o_raw_code == INVALID_RAW)
    `FSFD_ASSERT_NEXT(a_bus_error_keeps_discard, accept && i_kind, r_discard == $past(r_discard))

endmodule
